[hdl/dtq_pkg.sv]
// Shared constants, codes and transfer types of the delta timer queue.
package dtq_pkg;

    localparam int NUM_ALARMS = 16;
    localparam int TICK_BITS  = 16;
    localparam int SLOT_W     = $clog2(NUM_ALARMS + 1);
    localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NUM_ALARMS);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_EXPIRED = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef struct packed {
        t_req        req_type;
        logic [3:0]  alarm_id;
        logic [15:0] ticks;
    } t_in_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [3:0]  result_alarm;
        logic [15:0] remaining;
        logic        last;
    } t_out_item;

endpackage

[hdl/dtq_alu.sv]
// Shared add and subtract unit that does the delta arithmetic of the queue sequencer.
module dtq_alu (
    input  logic [dtq_pkg::TICK_BITS-1:0] i_a,
    input  logic [dtq_pkg::TICK_BITS-1:0] i_b,
    input  logic                          i_sub,
    output logic [dtq_pkg::TICK_BITS-1:0] o_sum,
    output logic                          o_carry
);
    import dtq_pkg::*;

    logic [TICK_BITS-1:0] b_op;
    logic [TICK_BITS:0]   total;

    assign b_op  = i_b ^ {TICK_BITS{i_sub}};
    assign total = {1'b0, i_a} + {1'b0, b_op} + (TICK_BITS + 1)'(i_sub);
    assign o_sum   = total[TICK_BITS-1:0];
    assign o_carry = total[TICK_BITS];

endmodule

[hdl/delta_timer_queue.sv]
// Top level of the delta timer queue: request sequencer, link memory and result register.
//
// Alarms sit in a linked list ordered by expiry, each entry holding its delta from the
// entry before it. A request is taken when start is high and busy is low; busy then stays
// high until the request is done. Add, cancel and query walk the list one entry per cycle
// through the single registered read port of the link memory; a request settled at dispatch
// needs no walk. A tick on an empty queue ends at dispatch; otherwise the head delta is
// decremented and one expired result follows per alarm that reached zero. Results appear
// on o_result for one cycle each, marked by o_strobe, at most one per cycle and in order;
// last is set on the final result of a request. The receiver cannot stall, so every
// strobed transfer must be taken at once.
module delta_timer_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dtq_pkg::t_in_item   i_req,
    output logic                o_strobe,
    output dtq_pkg::t_out_item  o_result
);
    import dtq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISP     = 11'b000_0000_0010,
        S_ADD_EV   = 11'b000_0000_0100,
        S_ADD_LINK = 11'b000_0000_1000,
        S_ADD_FIX  = 11'b000_0001_0000,
        S_CAN_EV   = 11'b000_0010_0000,
        S_CAN_FOLD = 11'b000_0100_0000,
        S_Q_EV     = 11'b000_1000_0000,
        S_TK_DEC   = 11'b001_0000_0000,
        S_TK_EV    = 11'b010_0000_0000,
        S_TK_FLUSH = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_in;
    logic [TICK_BITS-1:0]  r_t, n_t;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic [SLOT_W-1:0]     r_prev, n_prev;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic [NUM_ALARMS-1:0] r_queued, n_queued;
    logic [IDX_W-1:0]      r_pend, n_pend;
    t_out_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [TICK_BITS-1:0]  r_mem_delta [NUM_ALARMS];
    logic [SLOT_W-1:0]     r_mem_next  [NUM_ALARMS];
    logic [TICK_BITS-1:0]  r_rd_delta;
    logic [SLOT_W-1:0]     r_rd_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wd_en;
    logic [IDX_W-1:0]      wd_addr;
    logic [TICK_BITS-1:0]  wd_data;
    logic                  wn_en;
    logic [IDX_W-1:0]      wn_addr;
    logic [SLOT_W-1:0]     wn_data;

    logic [TICK_BITS-1:0]  alu_a, alu_b, alu_sum;
    logic                  alu_sub, alu_carry;

    logic [SLOT_W+3:0]     id_ext;
    logic                  id_ok;
    logic [IDX_W-1:0]      id_idx;
    logic [SLOT_W-1:0]     id_slot;
    logic [TICK_BITS+15:0] ticks_ext;
    logic [TICK_BITS+15:0] sum_ext;
    logic [IDX_W+3:0]      pend_ext;

    assign id_ext    = {SLOT_W'(0), r_in.alarm_id};
    assign id_ok     = id_ext < (SLOT_W + 4)'(NUM_ALARMS);
    assign id_idx    = id_ext[IDX_W-1:0];
    assign id_slot   = id_ext[SLOT_W-1:0];
    assign ticks_ext = {TICK_BITS'(0), i_req.ticks};
    assign sum_ext   = {16'(0), alu_sum};
    assign pend_ext  = {4'(0), r_pend};

    dtq_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_head      = r_head;
        n_queued    = r_queued;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_cur[IDX_W-1:0];
        wd_en       = 1'b0;
        wd_addr     = r_cur[IDX_W-1:0];
        wd_data     = alu_sum;
        wn_en       = 1'b0;
        wn_addr     = r_prev[IDX_W-1:0];
        wn_data     = id_slot;
        alu_a       = r_t;
        alu_b       = r_rd_delta;
        alu_sub     = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_t     = ticks_ext[TICK_BITS-1:0];
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                rd_en   = 1'b1;
                rd_addr = r_head[IDX_W-1:0];
                n_cur   = r_head;
                n_prev  = NO_SLOT;
                n_state = S_IDLE;
                n_out.result_alarm = r_in.alarm_id;
                n_out.remaining    = '0;
                n_out.last         = 1'b1;
                case (r_in.req_type)
                    REQ_ADD: begin
                        if (id_ok) begin
                            if (r_queued[id_idx]) begin
                                n_out.result_kind = KIND_REJECT;
                                n_out_valid       = 1'b1;
                            end else if (r_t == '0) begin
                                n_out.result_kind = KIND_EXPIRED;
                                n_out_valid       = 1'b1;
                            end else if (r_head == NO_SLOT) begin
                                n_state = S_ADD_LINK;
                            end else begin
                                n_state = S_ADD_EV;
                            end
                        end
                    end
                    REQ_CANCEL: begin
                        if (id_ok && r_queued[id_idx]) begin
                            n_state = S_CAN_EV;
                        end
                    end
                    REQ_QUERY: begin
                        if (id_ok && r_queued[id_idx]) begin
                            n_t     = '0;
                            n_state = S_Q_EV;
                        end else begin
                            n_out.result_kind = KIND_QUERY;
                            n_out_valid       = 1'b1;
                        end
                    end
                    REQ_TICK: begin
                        if (r_head != NO_SLOT) begin
                            n_state = S_TK_DEC;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ADD_EV: begin
                if (alu_carry && (alu_sum != '0)) begin
                    n_t    = alu_sum;
                    n_prev = r_cur;
                    n_cur  = r_rd_next;
                    if (r_rd_next == NO_SLOT) begin
                        n_state = S_ADD_LINK;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_next[IDX_W-1:0];
                    end
                end else begin
                    n_state = S_ADD_LINK;
                end
            end
            S_ADD_LINK: begin
                wd_en            = 1'b1;
                wd_addr          = id_idx;
                wd_data          = r_t;
                wn_en            = 1'b1;
                wn_addr          = id_idx;
                wn_data          = r_cur;
                n_queued[id_idx] = 1'b1;
                if (r_prev == NO_SLOT) begin
                    n_head = id_slot;
                end
                n_state = S_ADD_FIX;
            end
            S_ADD_FIX: begin
                alu_a = r_rd_delta;
                alu_b = r_t;
                if (r_prev != NO_SLOT) begin
                    wn_en = 1'b1;
                end
                if (r_cur != NO_SLOT) begin
                    wd_en = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_CAN_EV: begin
                n_cur = r_rd_next;
                if (r_cur == id_slot) begin
                    n_queued[id_idx] = 1'b0;
                    n_t              = r_rd_delta;
                    if (r_prev != NO_SLOT) begin
                        wn_en   = 1'b1;
                        wn_data = r_rd_next;
                    end else begin
                        n_head = r_rd_next;
                    end
                    if (r_rd_next != NO_SLOT) begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_next[IDX_W-1:0];
                        n_state = S_CAN_FOLD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_prev = r_cur;
                    if (r_rd_next != NO_SLOT) begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_next[IDX_W-1:0];
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CAN_FOLD: begin
                alu_a   = r_rd_delta;
                alu_b   = r_t;
                alu_sub = 1'b0;
                wd_en   = 1'b1;
                n_state = S_IDLE;
            end
            S_Q_EV: begin
                alu_sub            = 1'b0;
                n_t                = alu_sum;
                n_cur              = r_rd_next;
                n_out.result_kind  = KIND_QUERY;
                n_out.result_alarm = r_in.alarm_id;
                n_out.last         = 1'b1;
                if (r_cur == id_slot) begin
                    n_out.remaining = sum_ext[15:0];
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end else if (r_rd_next != NO_SLOT) begin
                    rd_en   = 1'b1;
                    rd_addr = r_rd_next[IDX_W-1:0];
                end else begin
                    n_out.remaining = '0;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_TK_DEC: begin
                alu_a = r_rd_delta;
                alu_b = TICK_BITS'(1);
                if (r_rd_delta != '0) begin
                    wd_en = 1'b1;
                end
                if ((r_rd_delta == '0) || (alu_sum == '0)) begin
                    n_pend                       = r_cur[IDX_W-1:0];
                    n_queued[r_cur[IDX_W-1:0]]   = 1'b0;
                    n_head                       = r_rd_next;
                    n_cur                        = r_rd_next;
                    if (r_rd_next == NO_SLOT) begin
                        n_state = S_TK_FLUSH;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_next[IDX_W-1:0];
                        n_state = S_TK_EV;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TK_EV: begin
                n_out.result_kind  = KIND_EXPIRED;
                n_out.result_alarm = pend_ext[3:0];
                n_out.remaining    = '0;
                n_out_valid        = 1'b1;
                if (r_rd_delta == '0) begin
                    n_out.last                 = 1'b0;
                    n_pend                     = r_cur[IDX_W-1:0];
                    n_queued[r_cur[IDX_W-1:0]] = 1'b0;
                    n_head                     = r_rd_next;
                    n_cur                      = r_rd_next;
                    if (r_rd_next == NO_SLOT) begin
                        n_state = S_TK_FLUSH;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_next[IDX_W-1:0];
                    end
                end else begin
                    n_out.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TK_FLUSH: begin
                n_out.result_kind  = KIND_EXPIRED;
                n_out.result_alarm = pend_ext[3:0];
                n_out.remaining    = '0;
                n_out.last         = 1'b1;
                n_out_valid        = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NO_SLOT;
            r_queued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_queued    <= n_queued;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && (r_state == S_IDLE)) begin
            r_in <= i_req;
        end
        r_t    <= n_t;
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wd_en) begin
            r_mem_delta[wd_addr] <= wd_data;
        end
        if (wn_en) begin
            r_mem_next[wn_addr] <= wn_data;
        end
        if (rd_en) begin
            r_rd_delta <= r_mem_delta[rd_addr];
            r_rd_next  <= r_mem_next[rd_addr];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    a_head_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && (r_head != NO_SLOT)) |-> r_queued[r_head[IDX_W-1:0]])
        else $error("queue head is not marked as queued");

    a_expiry_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("expiry burst ended without a last transfer");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.result_kind != KIND_EXPIRED)) |-> o_result.last)
        else $error("query or reject transfer without last");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

endmodule

[tb/sv/delta_timer_queue_tb.sv]
// Self-checking testbench of the delta timer queue: directed table, random requests, predictor.
module delta_timer_queue_tb;
    import dtq_pkg::*;

    typedef struct packed {
        t_in_item  it;
        logic      fixed;
        logic      has_res;
        t_out_item res;
    } t_row;

    localparam t_out_item NO_RES = '0;
    localparam int NUM_OPENING = 25;
    localparam int NUM_RANDOM = 260;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_req;
    logic      o_strobe;
    t_out_item o_result;

    logic [TICK_BITS-1:0] gap [NUM_ALARMS];
    logic [SLOT_W-1:0]    link [NUM_ALARMS];
    bit                   armed [NUM_ALARMS];
    logic [SLOT_W-1:0]    head_slot;

    t_out_item step_results [$];
    t_out_item awaited_results [$];
    int        fail_count;
    int        sent;

    t_row opening_rows [NUM_OPENING] = '{
        '{'{REQ_QUERY,  4'd5,  16'h0000}, 1'b1, 1'b1, '{KIND_QUERY, 4'd5, 16'h0000, 1'b1}},
        '{'{REQ_TICK,   4'd0,  16'h0000}, 1'b1, 1'b0, NO_RES},
        '{'{REQ_CANCEL, 4'd3,  16'h0000}, 1'b1, 1'b0, NO_RES},
        '{'{REQ_ADD,    4'd7,  16'h0000}, 1'b1, 1'b1, '{KIND_EXPIRED, 4'd7, 16'h0000, 1'b1}},
        '{'{REQ_ADD,    4'd0,  16'hFFFF}, 1'b1, 1'b0, NO_RES},
        '{'{REQ_QUERY,  4'd0,  16'h0000}, 1'b1, 1'b1, '{KIND_QUERY, 4'd0, 16'hFFFF, 1'b1}},
        '{'{REQ_ADD,    4'd0,  16'h0005}, 1'b1, 1'b1, '{KIND_REJECT, 4'd0, 16'h0000, 1'b1}},
        '{'{REQ_ADD,    4'd15, 16'h0001}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_ADD,    4'd1,  16'h0001}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_ADD,    4'd2,  16'h0003}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_ADD,    4'd3,  16'h0003}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_ADD,    4'd4,  16'h0002}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_QUERY,  4'd15, 16'h0000}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_QUERY,  4'd3,  16'h0000}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_CANCEL, 4'd2,  16'h0000}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_QUERY,  4'd3,  16'h0000}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_TICK,   4'd9,  16'h1234}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_TICK,   4'd0,  16'h0000}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_TICK,   4'd0,  16'h0000}, 1'b0, 1'b0, NO_RES},
        '{'{REQ_CANCEL, 4'd0,  16'h0000}, 1'b1, 1'b0, NO_RES},
        '{'{REQ_QUERY,  4'd0,  16'h0000}, 1'b1, 1'b1, '{KIND_QUERY, 4'd0, 16'h0000, 1'b1}},
        '{'{REQ_ADD,    4'd10, 16'hAAAA}, 1'b1, 1'b0, NO_RES},
        '{'{REQ_ADD,    4'd5,  16'h5555}, 1'b1, 1'b0, NO_RES},
        '{'{REQ_QUERY,  4'd10, 16'h0000}, 1'b1, 1'b1, '{KIND_QUERY, 4'd10, 16'hAAAA, 1'b1}},
        '{'{REQ_CANCEL, 4'd10, 16'h0000}, 1'b1, 1'b0, NO_RES}
    };

    delta_timer_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_out_item pack_result(t_kind k, logic [3:0] id,
                                              logic [15:0] rem, logic lst);
        t_out_item r;
        r.result_kind  = k;
        r.result_alarm = id;
        r.remaining    = rem;
        r.last         = lst;
        return r;
    endfunction

    function automatic void apply_request(t_in_item it);
        logic [SLOT_W-1:0]    prev;
        logic [SLOT_W-1:0]    cur;
        logic [SLOT_W-1:0]    nxt;
        logic [TICK_BITS-1:0] t;
        logic [TICK_BITS-1:0] sum;
        logic [3:0]           id;
        int                   guard;
        bit                   found;
        step_results.delete();
        id = it.alarm_id;
        t = it.ticks;
        prev = NO_SLOT;
        cur = head_slot;
        guard = 0;
        found = 1'b0;
        sum = '0;
        case (it.req_type)
            REQ_ADD: begin
                if (armed[id]) begin
                    step_results.push_back(pack_result(KIND_REJECT, id, '0, 1'b1));
                end else if (t == '0) begin
                    step_results.push_back(pack_result(KIND_EXPIRED, id, '0, 1'b1));
                end else begin
                    while (cur != NO_SLOT && gap[cur] < t && guard < NUM_ALARMS) begin
                        t = t - gap[cur];
                        prev = cur;
                        cur = link[cur];
                        guard++;
                    end
                    gap[id] = t;
                    link[id] = cur;
                    armed[id] = 1'b1;
                    if (prev != NO_SLOT) link[prev] = SLOT_W'(id);
                    else head_slot = SLOT_W'(id);
                    if (cur != NO_SLOT) gap[cur] = gap[cur] - t;
                end
            end
            REQ_CANCEL: begin
                if (armed[id]) begin
                    while (cur != NO_SLOT && guard < NUM_ALARMS && !found) begin
                        if (cur == SLOT_W'(id)) begin
                            nxt = link[cur];
                            if (prev != NO_SLOT) link[prev] = nxt;
                            else head_slot = nxt;
                            if (nxt != NO_SLOT) gap[nxt] = gap[nxt] + gap[cur];
                            armed[cur] = 1'b0;
                            found = 1'b1;
                        end else begin
                            prev = cur;
                            cur = link[cur];
                            guard++;
                        end
                    end
                end
            end
            REQ_QUERY: begin
                if (armed[id]) begin
                    while (cur != NO_SLOT && guard < NUM_ALARMS && !found) begin
                        sum = sum + gap[cur];
                        if (cur == SLOT_W'(id)) found = 1'b1;
                        else cur = link[cur];
                        guard++;
                    end
                end
                step_results.push_back(pack_result(KIND_QUERY, id, found ? sum : '0, 1'b1));
            end
            default: begin
                if (head_slot != NO_SLOT) begin
                    if (gap[head_slot] != '0) gap[head_slot] = gap[head_slot] - 1'b1;
                    while (head_slot != NO_SLOT && gap[head_slot] == '0
                           && guard < NUM_ALARMS) begin
                        cur = head_slot;
                        head_slot = link[cur];
                        armed[cur] = 1'b0;
                        step_results.push_back(pack_result(KIND_EXPIRED, cur[3:0], '0, 1'b0));
                        guard++;
                    end
                    if (step_results.size() > 0)
                        step_results[step_results.size()-1].last = 1'b1;
                end
            end
        endcase
    endfunction

    task automatic issue(t_in_item it, logic fixed, logic has_res, t_out_item res);
        start <= 1'b1;
        i_req <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_request(it);
        sent++;
        if (fixed) begin
            if (has_res) awaited_results.push_back(res);
        end else begin
            foreach (step_results[k]) awaited_results.push_back(step_results[k]);
        end
    endtask

    task automatic send(t_req req, int id, int ticks);
        t_in_item it;
        it.req_type = req;
        it.alarm_id = 4'(id);
        it.ticks = 16'(ticks);
        issue(it, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic pause(int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int pct);
        int pick;
        int ticks;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 10) ticks = 0;
        else if ($urandom_range(99) < 12) ticks = $urandom_range(65535);
        else ticks = $urandom_range(1, 12);
        if (pick < 30) send(REQ_ADD, $urandom_range(15), ticks);
        else if (pick < 42) send(REQ_CANCEL, $urandom_range(15), $urandom_range(65535));
        else if (pick < 78) send(REQ_TICK, $urandom_range(15), $urandom_range(65535));
        else send(REQ_QUERY, $urandom_range(15), $urandom_range(65535));
        pause(pct);
    endtask

    task automatic fill_and_drain(int pct);
        int ticks;
        ticks = $urandom_range(1, 3);
        for (int k = 0; k < NUM_ALARMS; k++) begin
            send(REQ_CANCEL, k, 0);
            pause(pct);
        end
        for (int k = 0; k < NUM_ALARMS; k++) begin
            send(REQ_ADD, k, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : ticks);
            pause(pct);
        end
        for (int k = 0; k < 3; k++) begin
            send(REQ_TICK, 0, 0);
            pause(pct);
        end
    endtask

    task automatic report(string what, t_out_item want, t_out_item got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d (kind/alarm/remaining/last)",
                     what, want.result_kind, want.result_alarm, want.remaining, want.last,
                     got.result_kind, got.result_alarm, got.remaining, got.last);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                report("unexpected result", NO_RES, o_result);
            end else begin
                want = awaited_results.pop_front();
                if (o_result.result_kind !== want.result_kind
                    || o_result.result_alarm !== want.result_alarm
                    || o_result.remaining !== want.remaining
                    || o_result.last !== want.last)
                    report("result mismatch", want, o_result);
            end
        end
    end

    initial begin
        int phase_pct [4] = '{0, 64, 0, 22};
        int waited;
        fail_count = 0;
        sent = 0;
        head_slot = NO_SLOT;
        foreach (armed[k]) begin
            armed[k] = 1'b0;
            gap[k] = '0;
            link[k] = '0;
        end
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening_rows[r]) begin
            issue(opening_rows[r].it, opening_rows[r].fixed, opening_rows[r].has_res,
                  opening_rows[r].res);
            pause(30);
        end
        fill_and_drain(0);
        for (int p = 0; p < 4; p++) begin
            waited = sent + NUM_RANDOM / 4;
            while (sent < waited) begin
                if ($urandom_range(99) < 2) fill_and_drain(phase_pct[p]);
                else send_random(phase_pct[p]);
            end
        end
        start <= 1'b0;
        waited = 0;
        while (awaited_results.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (NUM_ALARMS + 8) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $display("%0d expected results never arrived", awaited_results.size());
            fail_count += awaited_results.size();
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
